FILE: hw/rtl/lorect_pkg.sv
// Shared types and constants for the largest all-ones rectangle block.
// No dependencies.
`timescale 1ns / 1ps

package lorect_pkg;

   localparam int MAX_SIZE_DEF = 32;
   localparam int CSR_W        = 6;
   localparam int OUT_W        = 11;
   localparam int AREA_MAX     = 2047;
   localparam logic [CSR_W-1:0] SIZE_RESET = CSR_W'(32);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CORNER,
      ST_CAPTURE,
      ST_RUN,
      ST_DONE
   } lorect_state_type;

   typedef struct packed {
      logic idle;
      logic last_cell;
      logic result_vld;
   } lorect_status_type;

endpackage

FILE: hw/rtl/largest_ones_rectangle_area_top.sv
// Largest all-ones rectangle: cells in row-major order, one area per matrix.
// A non-final cell: table read in IDLE, table write in LOAD; req_tready is low in LOAD.
// The final cell starts the scan: for each (top, left, bottom) the CORNER and CAPTURE
// states read the corner prefixes, then RUN widens one column per step over the two
// read ports of the prefix table. Reset is synchronous; no table clearing pass.
`timescale 1ns / 1ps

module largest_ones_rectangle_area_top import lorect_pkg::*; #(
   parameter int MAX_SIZE = MAX_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [0] cell_bit, [7:1] zero
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // [10:0] largest_area, [15:11] zero
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_data     // matrix_size
);

   localparam int CW = $clog2(MAX_SIZE + 1);

   logic [CSR_W-1:0]   matrix_size_ff, matrix_size_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_area_ff, rsp_area_in;
   logic [CW-1:0]      size_eff;
   logic               csr_fire;
   logic               out_free;
   logic               load_rsp;
   lorect_status_type  status;
   logic [OUT_W-1:0]   result_area;

   assign size_eff = (matrix_size_ff == CSR_W'(0)) ? CW'(1) :
                     ({1'b0, matrix_size_ff} > (CSR_W+1)'(MAX_SIZE)) ? CW'(MAX_SIZE) :
                     CW'(matrix_size_ff);

   assign csr_ready  = status.idle && !rsp_valid_ff;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = status.idle && !csr_fire;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load_rsp   = status.result_vld && out_free;

   lorect_seq #(.MAX_SIZE(MAX_SIZE)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .size        (size_eff),
      .restart     (csr_fire),
      .cell_vld    (req_tvalid && req_tready),
      .cell_bit    (req_tdata[0]),
      .out_free    (out_free),
      .status      (status),
      .result_area (result_area)
   );

   always_comb begin
      matrix_size_in = csr_fire ? csr_data : matrix_size_ff;
      rsp_valid_in   = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_area_in    = load_rsp ? result_area : rsp_area_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_size_ff <= SIZE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         matrix_size_ff <= matrix_size_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_area_ff <= rsp_area_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(16 - OUT_W)'(0), rsp_area_ff};

   a_load_two_cycles: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !status.last_cell) |=> !req_tready ##1 status.idle)
      else $error("non-final cell did not return to idle after one load cycle");

   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(status.result_vld))
      else $error("request result raised without a finished scan");

   a_area_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({3'b000, rsp_tdata[10:0]} <= (14'(size_eff) * 14'(size_eff))))
      else $error("result area exceeds matrix area");

endmodule

FILE: hw/rtl/lorect_ram.sv
// Prefix-count store: one write port, two registered read ports.
// Row 0 and column 0 are the zero border and read as zero without storage.
// Depends on lorect_pkg.
`timescale 1ns / 1ps

module lorect_ram import lorect_pkg::*; #(
   parameter int MAX_SIZE = MAX_SIZE_DEF
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [$clog2(MAX_SIZE+1)-1:0]             wr_row,
   input  logic [$clog2(MAX_SIZE+1)-1:0]             wr_col,
   input  logic [$clog2(MAX_SIZE*MAX_SIZE+1)-1:0]    wr_data,
   input  logic [$clog2(MAX_SIZE+1)-1:0]             rd_a_row,
   input  logic [$clog2(MAX_SIZE+1)-1:0]             rd_a_col,
   input  logic [$clog2(MAX_SIZE+1)-1:0]             rd_b_row,
   input  logic [$clog2(MAX_SIZE+1)-1:0]             rd_b_col,
   output logic [$clog2(MAX_SIZE*MAX_SIZE+1)-1:0]    rd_a_data,
   output logic [$clog2(MAX_SIZE*MAX_SIZE+1)-1:0]    rd_b_data
);

   localparam int CW    = $clog2(MAX_SIZE + 1);
   localparam int PW    = $clog2(MAX_SIZE * MAX_SIZE + 1);
   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AD    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [PW-1:0] mem_ff [DEPTH];
   logic [PW-1:0] rd_a_raw_ff;
   logic [PW-1:0] rd_b_raw_ff;
   logic          rd_a_zero_ff;
   logic          rd_b_zero_ff;
   logic [AD-1:0] wr_addr;
   logic [AD-1:0] rd_a_addr;
   logic [AD-1:0] rd_b_addr;

   // entry (r, c) with r, c >= 1 lives at (r-1)*MAX_SIZE + (c-1)
   assign wr_addr   = AD'(32'(wr_row - 1'b1) * MAX_SIZE + 32'(wr_col - 1'b1));
   assign rd_a_addr = AD'(32'(rd_a_row - 1'b1) * MAX_SIZE + 32'(rd_a_col - 1'b1));
   assign rd_b_addr = AD'(32'(rd_b_row - 1'b1) * MAX_SIZE + 32'(rd_b_col - 1'b1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_raw_ff  <= mem_ff[rd_a_addr];
      rd_b_raw_ff  <= mem_ff[rd_b_addr];
      rd_a_zero_ff <= (rd_a_row == CW'(0)) || (rd_a_col == CW'(0));
      rd_b_zero_ff <= (rd_b_row == CW'(0)) || (rd_b_col == CW'(0));
   end

   assign rd_a_data = rd_a_zero_ff ? '0 : rd_a_raw_ff;
   assign rd_b_data = rd_b_zero_ff ? '0 : rd_b_raw_ff;

endmodule

FILE: hw/rtl/lorect_seq.sv
// Sequencer: loads the prefix table cell by cell, then scans all rectangles
// with one shared add/compare unit over the two read ports of lorect_ram.
// Depends on lorect_pkg and lorect_ram.
`timescale 1ns / 1ps

module lorect_seq import lorect_pkg::*; #(
   parameter int MAX_SIZE = MAX_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(MAX_SIZE+1)-1:0]   size,
   input  logic                            restart,
   input  logic                            cell_vld,
   input  logic                            cell_bit,
   input  logic                            out_free,
   output lorect_status_type               status,
   output logic [OUT_W-1:0]                result_area
);

   localparam int CW = $clog2(MAX_SIZE + 1);
   localparam int PW = $clog2(MAX_SIZE * MAX_SIZE + 1);

   lorect_state_type state_ff, state_in;

   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] rowsum_ff, rowsum_in;
   logic [CW-1:0] top_ff, top_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] bot_ff, bot_in;
   logic [CW-1:0] ecol_ff, ecol_in;
   logic [PW-1:0] ctl_ff, ctl_in;
   logic [PW-1:0] cbl_ff, cbl_in;
   logic [PW-1:0] area_ff, area_in;
   logic [PW-1:0] best_ff, best_in;

   logic          wr_en;
   logic [CW-1:0] wr_row, wr_col;
   logic [PW-1:0] wr_data;
   logic [CW-1:0] rd_a_row, rd_a_col, rd_b_row, rd_b_col;
   logic [PW-1:0] rd_a_data, rd_b_data;

   logic          last_pos;
   logic          scan_more;
   logic          scan_finish;
   logic          skip;
   logic          hit;
   logic [CW-1:0] height;
   logic [PW-1:0] ones;
   logic [PW:0]   best_ext;

   lorect_ram #(.MAX_SIZE(MAX_SIZE)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_row    (wr_row),
      .wr_col    (wr_col),
      .wr_data   (wr_data),
      .rd_a_row  (rd_a_row),
      .rd_a_col  (rd_a_col),
      .rd_b_row  (rd_b_row),
      .rd_b_col  (rd_b_col),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign last_pos = (row_ff == size - 1'b1) && (col_ff == size - 1'b1);
   assign height   = bot_ff - top_ff + 1'b1;
   assign ones     = (rd_a_data + ctl_ff) - (rd_b_data + cbl_ff);
   assign hit      = (ones == area_ff);
   assign skip     = !hit && (ecol_ff == left_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cell_vld && !restart) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = last_pos ? ST_CORNER : ST_IDLE;
         end
         ST_CORNER:  state_in = ST_CAPTURE;
         ST_CAPTURE: state_in = ST_RUN;
         ST_RUN: begin
            if (!scan_more) state_in = scan_finish ? ST_DONE : ST_CORNER;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      rowsum_in   = rowsum_ff;
      top_in      = top_ff;
      left_in     = left_ff;
      bot_in      = bot_ff;
      ecol_in     = ecol_ff;
      ctl_in      = ctl_ff;
      cbl_in      = cbl_ff;
      area_in     = area_ff;
      best_in     = best_ff;
      wr_en       = 1'b0;
      wr_row      = row_ff + 1'b1;
      wr_col      = col_ff + 1'b1;
      wr_data     = rd_a_data + PW'(rowsum_ff);
      rd_a_row    = row_ff;
      rd_a_col    = col_ff + 1'b1;
      rd_b_row    = top_ff - 1'b1;
      rd_b_col    = left_ff - 1'b1;
      scan_more   = 1'b0;
      scan_finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (restart) begin
               row_in = '0;
               col_in = '0;
            end else if (cell_vld) begin
               rowsum_in = ((col_ff == CW'(0)) ? CW'(0) : rowsum_ff) + CW'(cell_bit);
            end
         end
         ST_LOAD: begin
            wr_en = 1'b1;
            if (col_ff + 1'b1 < size) begin
               col_in = col_ff + 1'b1;
            end else begin
               col_in = '0;
               row_in = (row_ff + 1'b1 < size) ? row_ff + 1'b1 : CW'(0);
            end
            if (last_pos) begin
               top_in  = CW'(1);
               left_in = CW'(1);
               bot_in  = CW'(1);
               best_in = '0;
            end
         end
         ST_CORNER: begin
            rd_a_row = top_ff - 1'b1;
            rd_a_col = left_ff - 1'b1;
            rd_b_row = bot_ff;
            rd_b_col = left_ff - 1'b1;
         end
         ST_CAPTURE: begin
            ctl_in   = rd_a_data;
            cbl_in   = rd_b_data;
            rd_a_row = bot_ff;
            rd_a_col = left_ff;
            rd_b_row = top_ff - 1'b1;
            rd_b_col = left_ff;
            ecol_in  = left_ff;
            area_in  = PW'(height);
         end
         ST_RUN: begin
            if (hit && (area_ff > best_ff)) best_in = area_ff;
            scan_more = hit && (ecol_ff != size);
            rd_a_row  = bot_ff;
            rd_a_col  = ecol_ff + 1'b1;
            rd_b_row  = top_ff - 1'b1;
            rd_b_col  = ecol_ff + 1'b1;
            if (scan_more) begin
               ecol_in = ecol_ff + 1'b1;
               area_in = area_ff + PW'(height);
            end else if (!skip && (bot_ff != size)) begin
               bot_in = bot_ff + 1'b1;
            end else if (left_ff != size) begin
               left_in = left_ff + 1'b1;
               bot_in  = top_ff;
            end else if (top_ff != size) begin
               top_in  = top_ff + 1'b1;
               left_in = CW'(1);
               bot_in  = top_ff + 1'b1;
            end else begin
               scan_finish = 1'b1;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         row_ff    <= '0;
         col_ff    <= '0;
         rowsum_ff <= '0;
         top_ff    <= '0;
         left_ff   <= '0;
         bot_ff    <= '0;
         ecol_ff   <= '0;
         best_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         rowsum_ff <= rowsum_in;
         top_ff    <= top_in;
         left_ff   <= left_in;
         bot_ff    <= bot_in;
         ecol_ff   <= ecol_in;
         best_ff   <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff  <= ctl_in;
      cbl_ff  <= cbl_in;
      area_ff <= area_in;
   end

   // saturate to the output width
   assign best_ext    = {1'b0, best_ff};
   assign result_area = (best_ext > (PW+1)'(AREA_MAX)) ? OUT_W'(AREA_MAX) : OUT_W'(best_ff);

   assign status.idle       = (state_ff == ST_IDLE);
   assign status.last_cell  = last_pos;
   assign status.result_vld = (state_ff == ST_DONE);

endmodule

FILE: bench/tb_largest_ones_rectangle_area_top.sv
// Testbench for largest_ones_rectangle_area_top: streams binary matrices cell by cell
// and checks each area against a prefix-sum predictor kept in a small scoreboard class.
// Depends on lorect_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_largest_ones_rectangle_area_top import lorect_pkg::*;;

   localparam int TBL = MAX_SIZE_DEF + 1;

   typedef enum int {SH_NOISE, SH_DENSE, SH_FULL, SH_EMPTY, SH_BLOCK} shape_type;
   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   class area_board;
      int unsigned size_reg;
      int unsigned row, col;
      int unsigned tbl[TBL][TBL];
      logic [OUT_W-1:0] expected_areas[$];
      int unsigned errs, checked, cells;

      function new();
         size_reg = SIZE_RESET;
         row = 0;
         col = 0;
         errs = 0;
         checked = 0;
         cells = 0;
         foreach (tbl[i, j]) tbl[i][j] = 0;
      endfunction

      function int unsigned side();
         int unsigned n;
         n = size_reg;
         if (n == 0) n = 1;
         if (n > MAX_SIZE_DEF) n = MAX_SIZE_DEF;
         return n;
      endfunction

      function void set_size(logic [CSR_W-1:0] v);
         size_reg = v;
         row = 0;
         col = 0;
      endfunction

      // every rectangle, widening to the right until a zero shows up
      function int unsigned largest_block(int unsigned n);
         int unsigned best, ones, area;
         best = 0;
         for (int unsigned t = 1; t <= n; t++)
            for (int unsigned l = 1; l <= n; l++)
               for (int unsigned b = t; b <= n; b++)
                  for (int unsigned r = l; r <= n; r++) begin
                     ones = (tbl[b][r] + tbl[t-1][l-1]) - (tbl[t-1][r] + tbl[b][l-1]);
                     area = (b - t + 1) * (r - l + 1);
                     if (ones != area) break;
                     if (area > best) best = area;
                  end
         return best;
      endfunction

      function void note_cell(bit b);
         int unsigned n, r, c, area;
         n = side();
         if (row >= n || col >= n) begin
            row = 0;
            col = 0;
         end
         r = row;
         c = col;
         tbl[r+1][c+1] = b + tbl[r][c+1] + tbl[r+1][c] - tbl[r][c];
         cells++;
         if (c + 1 < n) begin
            col = c + 1;
            return;
         end
         col = 0;
         if (r + 1 < n) begin
            row = r + 1;
            return;
         end
         row = 0;
         area = largest_block(n);
         if (area > AREA_MAX) area = AREA_MAX;
         expected_areas.push_back(OUT_W'(area));
      endfunction

      function void check_area(logic [15:0] d);
         logic [OUT_W-1:0] want, got;
         got = d[OUT_W-1:0];
         if (expected_areas.size() == 0) begin
            errs++;
            if (errs <= 10) $display("unexpected area %0d", got);
            return;
         end
         want = expected_areas.pop_front();
         checked++;
         if (got !== want) begin
            errs++;
            if (errs <= 10) $display("area mismatch: expected %0d, got %0d", want, got);
         end
      endfunction

      function void count_leftovers();
         if (expected_areas.size() != 0) begin
            errs += expected_areas.size();
            $display("%0d areas never arrived", expected_areas.size());
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_data = '0;

   area_board sb = new();
   int unsigned send_idle = 0;
   int unsigned recv_stall = 0;
   int unsigned cells_sent = 0;
   int unsigned size_writes = 0;

   largest_ones_rectangle_area_top #(.MAX_SIZE(MAX_SIZE_DEF)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_area(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin send_idle = 0;  recv_stall = 0;  end
         IDLE_SEND: begin send_idle = 46; recv_stall = 0;  end
         IDLE_RECV: begin send_idle = 0;  recv_stall = 46; end
         default: begin send_idle = 28; recv_stall = 28; end
      endcase
   endtask

   task automatic send_cell(bit b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, b};
      do @(posedge clock); while (!req_tready);
      sb.note_cell(b);
      cells_sent++;
   endtask

   // sender holds off until every area is in and the last cell is written
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_areas.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_size(logic [CSR_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_size(v);
      size_writes++;
   endtask

   task automatic send_bits(int unsigned count, logic [31:0] bits);
      for (int unsigned k = 0; k < count; k++) send_cell(bits[k]);
   endtask

   function automatic shape_type pick_shape();
      case ($urandom_range(0, 9))
         0, 1:    return SH_NOISE;
         2, 3, 4: return SH_DENSE;
         5:       return SH_FULL;
         6:       return SH_EMPTY;
         default: return SH_BLOCK;
      endcase
   endfunction

   task automatic send_matrix(int unsigned n, shape_type sh, int unsigned ncells);
      int unsigned r0, r1, c0, c1, r, c;
      bit b;
      r0 = $urandom_range(0, n - 1);
      r1 = $urandom_range(r0, n - 1);
      c0 = $urandom_range(0, n - 1);
      c1 = $urandom_range(c0, n - 1);
      for (int unsigned k = 0; k < ncells; k++) begin
         r = k / n;
         c = k % n;
         case (sh)
            SH_NOISE: b = $urandom_range(0, 1);
            SH_DENSE: b = ($urandom_range(99) < 85);
            SH_FULL:  b = 1'b1;
            SH_EMPTY: b = 1'b0;
            default:  b = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ||
                          ($urandom_range(99) < 30);
         endcase
         send_cell(b);
      end
   endtask

   initial begin
      int unsigned n, target, pick;
      logic [CSR_W-1:0] sz;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: size zero, size one, first-row zeros, restart mid-matrix
      set_idling(IDLE_NONE);
      write_size(6'd0);
      send_bits(2, 32'b10);
      write_size(6'd1);
      send_bits(1, 32'b1);
      write_size(6'd2);
      send_bits(4, 32'b1111);
      send_bits(4, 32'b1100);
      send_bits(3, 32'b101);
      write_size(6'd3);
      send_bits(9, 32'b011_111_110);

      for (int unsigned mode = 0; mode < 4; mode++) begin
         set_idling(idle_mode_type'(mode));
         target = cells_sent + 60;
         while (cells_sent < target) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) sz = 6'd0;
            else if (pick == 1) sz = CSR_W'($urandom_range(9, 12));
            else sz = CSR_W'($urandom_range(1, 8));
            write_size(sz);
            n = sb.side();
            repeat ($urandom_range(1, 3)) send_matrix(n, pick_shape(), n * n);
            if (n > 1 && $urandom_range(0, 4) == 0)
               send_matrix(n, pick_shape(), $urandom_range(1, n * n - 1));
         end
      end

      // oversized register value, clamped to the largest matrix
      set_idling(IDLE_BOTH);
      write_size(6'd63);
      send_matrix(MAX_SIZE_DEF, SH_BLOCK, MAX_SIZE_DEF * MAX_SIZE_DEF);

      drain();
      repeat (20) @(posedge clock);
      sb.count_leftovers();
      $display("covered %0d cells, %0d areas checked, %0d size writes (sizes 0 to 63)",
               cells_sent, sb.checked, size_writes);
      $display("idling mixes: none, sender only, receiver only, both; %0d errors", sb.errs);
      if (sb.errs == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/lorect_pkg.sv
hw/rtl/lorect_ram.sv
hw/rtl/lorect_seq.sv
hw/rtl/largest_ones_rectangle_area_top.sv
bench/tb_largest_ones_rectangle_area_top.sv
